/* sv/pump_run_cycle_monitor_defines.svh */
// assertion helpers shared by the pump monitor rtl
`ifndef PUMP_RUN_CYCLE_MONITOR_DEFINES_SVH
`define PUMP_RUN_CYCLE_MONITOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PRCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PRCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/prcm_pkg.sv */
`timescale 1ns / 1ps

package prcm_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DebW    = 16;
  localparam int unsigned SecW    = 23;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LEVEL  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SAVE_INTERVAL = 2'd2;

  localparam logic [DebW-1:0]  DEBOUNCE_RST      = 16'd50;
  localparam logic [TimeW-1:0] SAVE_INTERVAL_RST = 32'd300000;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam int unsigned RecipW      = 29;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned ProdW       = TimeW + RecipW;
  localparam logic [RecipW-1:0] RECIP_1000 = 29'd274877907;

  typedef struct packed {
    logic [DebW-1:0]  debounce_ms;
    logic             active_level;
    logic [TimeW-1:0] save_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic             pump_on;
    logic             pump_started;
    logic             pump_stopped;
    logic [TimeW-1:0] cycle_count;
    logic [TimeW-1:0] run_ms;
    logic [TimeW-1:0] current_run_ms;
    logic             save_due;
  } edge_res_t;

endpackage

/* sv/prcm_edge_track.sv */
`timescale 1ns / 1ps

module prcm_edge_track import prcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             smp_vld_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             pin_level_i,
  input  cfg_t             cfg_i,
  output edge_res_t        res_o
);

  logic             acc_level_q, acc_level_d;
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic             running_q, running_d;
  logic [TimeW-1:0] start_time_q, start_time_d;
  logic [TimeW-1:0] starts_q, starts_d;
  logic [TimeW-1:0] last_save_q, last_save_d;
  edge_res_t        res_q, res_d;

  logic             act;
  logic             edge_ok;
  logic             start;
  logic             stop;
  logic             save;
  logic [TimeW-1:0] edge_gap;
  logic [TimeW-1:0] run_gap;
  logic [TimeW-1:0] save_gap;

  always_comb begin
    act      = (pin_level_i == cfg_i.active_level);
    edge_gap = now_ms_i - last_edge_q;
    run_gap  = now_ms_i - start_time_q;
    save_gap = now_ms_i - last_save_q;
    edge_ok  = (act != acc_level_q) && (edge_gap >= TimeW'(cfg_i.debounce_ms));
    start    = edge_ok && act && !running_q;
    stop     = edge_ok && !act && running_q;
    save     = (save_gap >= cfg_i.save_interval_ms);

    acc_level_d  = edge_ok ? act : acc_level_q;
    last_edge_d  = edge_ok ? now_ms_i : last_edge_q;
    running_d    = start ? 1'b1 : (stop ? 1'b0 : running_q);
    start_time_d = start ? now_ms_i : start_time_q;
    starts_d     = starts_q + TimeW'(start);
    last_save_d  = save ? now_ms_i : last_save_q;

    res_d.pump_on        = running_d;
    res_d.pump_started   = start;
    res_d.pump_stopped   = stop;
    res_d.cycle_count    = starts_d;
    res_d.run_ms         = run_gap;
    res_d.current_run_ms = (running_q && !stop) ? run_gap : '0;
    res_d.save_due       = save;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_level_q  <= 1'b0;
      last_edge_q  <= '0;
      running_q    <= 1'b0;
      start_time_q <= '0;
      starts_q     <= '0;
      last_save_q  <= '0;
    end else if (en_i && smp_vld_i) begin
      acc_level_q  <= acc_level_d;
      last_edge_q  <= last_edge_d;
      running_q    <= running_d;
      start_time_q <= start_time_d;
      starts_q     <= starts_d;
      last_save_q  <= last_save_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* sv/pump_run_cycle_monitor.sv */
// pump run-time and start counter
// input channel: one transfer per sample, now_ms_i (free-running ms time)
// and pin_level_i (raw indicator level), valid/ready
// output channel: one transfer per sample with the debounced run flag,
// start/stop pulses, start count, total and last run seconds, live run
// length in ms and a save-due pulse, valid/ready
// config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i at once
// (0 debounce ms, 1 active level, 2 save interval ms); the user must write
// only while idle, which the block does not enforce; one sample is taken
// every cycle unless the receiver stalls; the pipeline is input register,
// edge/state stage, reciprocal multiply for the ms-to-seconds step, then
// the result register where the seconds total is summed
// when the receiver stalls the whole pipeline holds and in_ready_o drops;
// it rises again in the cycle the waiting result is taken
// reset clears all counters and the run state and loads the register
// defaults (50 ms debounce, active low, 300000 ms save interval)
`timescale 1ns / 1ps

`include "pump_run_cycle_monitor_defines.svh"

module pump_run_cycle_monitor import prcm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic               pin_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               pump_on_o,
  output logic               pump_started_o,
  output logic               pump_stopped_o,
  output logic [TimeW-1:0]   cycle_count_o,
  output logic [TimeW-1:0]   on_time_sec_o,
  output logic [SecW-1:0]    last_run_sec_o,
  output logic [TimeW-1:0]   current_run_ms_o,
  output logic               save_due_o
);

  cfg_t             cfg_q;
  logic             en;

  logic             in_vld_q;
  logic [TimeW-1:0] now_q;
  logic             lvl_q;

  logic             s1_vld_q;
  edge_res_t        s1_res;

  logic             s2_vld_q;
  edge_res_t        s2_res_q;
  logic [ProdW-1:0] prod_q, prod_d;

  logic             out_vld_q;
  logic [SecW-1:0]  secs;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= DEBOUNCE_RST;
      cfg_q.active_level     <= 1'b0;
      cfg_q.save_interval_ms <= SAVE_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DEBOUNCE:      cfg_q.debounce_ms      <= cfg_wdata_i[DebW-1:0];
        CFG_ACTIVE_LEVEL:  cfg_q.active_level     <= cfg_wdata_i[0];
        CFG_SAVE_INTERVAL: cfg_q.save_interval_ms <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= in_valid_i;
      s1_vld_q  <= in_vld_q;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en) begin
      now_q <= now_ms_i;
      lvl_q <= pin_level_i;
    end
  end

  prcm_edge_track u_edge_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .smp_vld_i   (in_vld_q),
    .now_ms_i    (now_q),
    .pin_level_i (lvl_q),
    .cfg_i       (cfg_q),
    .res_o       (s1_res)
  );

  // ms to seconds by reciprocal multiply
  assign prod_d = ProdW'(s1_res.run_ms) * ProdW'(RECIP_1000);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= prod_d;
      s2_res_q <= s1_res;
    end
  end

  assign secs = prod_q[RECIP_SHIFT +: SecW];

  // result register, seconds totals live here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_sec_o  <= '0;
      last_run_sec_o <= '0;
    end else if (en && s2_vld_q && s2_res_q.pump_stopped) begin
      on_time_sec_o  <= on_time_sec_o + TimeW'(secs);
      last_run_sec_o <= secs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pump_on_o        <= s2_res_q.pump_on;
      pump_started_o   <= s2_res_q.pump_started;
      pump_stopped_o   <= s2_res_q.pump_stopped;
      cycle_count_o    <= s2_res_q.cycle_count;
      current_run_ms_o <= s2_res_q.current_run_ms;
      save_due_o       <= s2_res_q.save_due;
    end
  end

  assign out_valid_o = out_vld_q;

  `PRCM_ASSERT_NOW(a_start_stop_excl, clk_i, rst_ni, out_valid_o,
    !(pump_started_o && pump_stopped_o), "start and stop in one transfer")
  `PRCM_ASSERT_NOW(a_start_runs, clk_i, rst_ni, out_valid_o && pump_started_o,
    pump_on_o && (current_run_ms_o == '0), "start without running flag")
  `PRCM_ASSERT_NOW(a_idle_zero_run, clk_i, rst_ni, out_valid_o && !pump_on_o,
    current_run_ms_o == '0, "run length while stopped")
  `PRCM_ASSERT_NEXT(a_total_only_on_stop, clk_i, rst_ni, !(en && s2_vld_q && s2_res_q.pump_stopped),
    $stable(on_time_sec_o) && $stable(last_run_sec_o), "seconds total moved without stop")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench import prcm_pkg::*; ();

  localparam int unsigned MsPerSec = 1000;
  localparam int unsigned Latency  = 3;

  typedef struct packed {
    logic             pump_on;
    logic             pump_started;
    logic             pump_stopped;
    logic [TimeW-1:0] cycle_count;
    logic [TimeW-1:0] on_time_sec;
    logic [SecW-1:0]  last_run_sec;
    logic [TimeW-1:0] current_run_ms;
    logic             save_due;
  } sample_result_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr_i = CFG_DEBOUNCE;
  logic [CfgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [TimeW-1:0]   now_ms_i = '0;
  logic               pin_level_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b1;
  logic               pump_on_o;
  logic               pump_started_o;
  logic               pump_stopped_o;
  logic [TimeW-1:0]   cycle_count_o;
  logic [TimeW-1:0]   on_time_sec_o;
  logic [SecW-1:0]    last_run_sec_o;
  logic [TimeW-1:0]   current_run_ms_o;
  logic               save_due_o;

  pump_run_cycle_monitor DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .now_ms_i,
    .pin_level_i,
    .out_valid_o,
    .out_ready_i,
    .pump_on_o,
    .pump_started_o,
    .pump_stopped_o,
    .cycle_count_o,
    .on_time_sec_o,
    .last_run_sec_o,
    .current_run_ms_o,
    .save_due_o
  );

  // monitor configuration and state as predicted
  logic [DebW-1:0]  cfg_debounce;
  logic             cfg_active;
  logic [TimeW-1:0] cfg_save_interval;
  logic             lvl_accepted;
  logic [TimeW-1:0] edge_ms;
  logic             run_flag;
  logic [TimeW-1:0] run_start_ms;
  logic [TimeW-1:0] start_count;
  logic [TimeW-1:0] total_sec;
  logic [SecW-1:0]  prev_run_sec;
  logic [TimeW-1:0] run_ms;
  logic [TimeW-1:0] save_ms;

  sample_result_t expected_samples[$];
  sample_result_t head_r;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  int n_samples = 0;
  int n_starts = 0;
  int n_stops = 0;
  int n_saves = 0;
  int n_settings = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void reset_predictor();
    cfg_debounce      = DEBOUNCE_RST;
    cfg_active        = 1'b0;
    cfg_save_interval = SAVE_INTERVAL_RST;
    lvl_accepted      = 1'b0;
    edge_ms           = '0;
    run_flag          = 1'b0;
    run_start_ms      = '0;
    start_count       = '0;
    total_sec         = '0;
    prev_run_sec      = '0;
    run_ms            = '0;
    save_ms           = '0;
  endfunction

  function automatic void predict_sample(logic [TimeW-1:0] t, logic lvl);
    logic             act;
    logic [TimeW-1:0] since_edge;
    logic [TimeW-1:0] since_save;
    logic [TimeW-1:0] secs;
    sample_result_t   r;
    r = '0;
    act = (lvl == cfg_active);
    since_edge = t - edge_ms;
    if (act != lvl_accepted && since_edge >= TimeW'(cfg_debounce)) begin
      edge_ms = t;
      if (act && !run_flag) begin
        run_flag = 1'b1;
        run_start_ms = t;
        start_count = start_count + 1;
        r.pump_started = 1'b1;
      end else if (!act && run_flag) begin
        secs = (t - run_start_ms) / MsPerSec;
        run_flag = 1'b0;
        prev_run_sec = secs[SecW-1:0];
        total_sec = total_sec + secs;
        run_ms = '0;
        r.pump_stopped = 1'b1;
      end
      lvl_accepted = act;
    end
    if (run_flag) run_ms = t - run_start_ms;
    since_save = t - save_ms;
    if (since_save >= cfg_save_interval) begin
      save_ms = t;
      r.save_due = 1'b1;
    end
    r.pump_on        = run_flag;
    r.cycle_count    = start_count;
    r.on_time_sec    = total_sec;
    r.last_run_sec   = prev_run_sec;
    r.current_run_ms = run_ms;
    expected_samples.push_back(r);
    n_samples++;
    n_starts += r.pump_started;
    n_stops  += r.pump_stopped;
    n_saves  += r.save_due;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("mismatch: %s at result %0d, expected %h, got %h",
             what, results_seen, want, got);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) report_mismatch(name, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        head_r = expected_samples.pop_front();
        check_field("pump_on", head_r.pump_on, pump_on_o);
        check_field("pump_started", head_r.pump_started, pump_started_o);
        check_field("pump_stopped", head_r.pump_stopped, pump_stopped_o);
        check_field("cycle_count", head_r.cycle_count, cycle_count_o);
        check_field("on_time_sec", head_r.on_time_sec, on_time_sec_o);
        check_field("last_run_sec", head_r.last_run_sec, last_run_sec_o);
        check_field("current_run_ms", head_r.current_run_ms, current_run_ms_o);
        check_field("save_due", head_r.save_due, save_due_o);
      end
      results_seen++;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_sample(input logic [TimeW-1:0] t, input logic lvl);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    now_ms_i    <= t;
    pin_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(t, lvl);
  endtask

  // wait until every sample has come back and the pipeline is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (Latency + 1) @(posedge clk_i);
  endtask

  task automatic configure(input logic [DebW-1:0] deb, input logic act,
                           input logic [TimeW-1:0] interval);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_DEBOUNCE;
    cfg_wdata_i <= CfgW'(deb);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_ACTIVE_LEVEL;
    cfg_wdata_i <= CfgW'(act);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_SAVE_INTERVAL;
    cfg_wdata_i <= CfgW'(interval);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_debounce      = deb;
    cfg_active        = act;
    cfg_save_interval = interval;
    n_settings++;
  endtask

  function automatic logic [TimeW-1:0] advance_ms(logic [TimeW-1:0] t);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2) return $urandom;
    if (pick < 7) return t + $urandom_range(200000);
    return t + $urandom_range(300);
  endfunction

  // reset defaults: window rejection, start, stop, wrap and backwards time
  task automatic test_debounce_edges();
    send_sample(32'd0, 1'b1);
    send_sample(32'd10, 1'b0);
    send_sample(32'd50, 1'b0);
    send_sample(32'd60, 1'b1);
    send_sample(32'd2049, 1'b1);
    send_sample(32'd300000, 1'b0);
    send_sample(32'd299999, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'd999, 1'b1);
    settle();
  endtask

  task automatic test_register_extremes();
    // zero window and zero save interval, active high
    configure('0, 1'b1, '0);
    send_sample(32'd5, 1'b1);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b1);
    settle();
    // widest window and widest save interval
    configure('1, 1'b1, '1);
    send_sample(32'd70000, 1'b0);
    send_sample(32'd70001, 1'b1);
    send_sample(32'd135535, 1'b1);
    send_sample(32'd201069, 1'b0);
    send_sample(32'd4, 1'b0);
    settle();
  endtask

  task automatic test_backpressure();
    logic [TimeW-1:0] t;
    logic             lvl;
    configure(16'd20, 1'b0, 32'd500);
    send_idle_pct = 0;
    stall_pct = 0;
    t = 32'd1000;
    lvl = 1'b1;
    hold_left = 80;
    for (int i = 0; i < 30; i++) begin
      t = t + $urandom_range(1, 400);
      if (i % 6 == 0) lvl = ~lvl;
      send_sample(t, lvl);
    end
    settle();
    stall_pct = 54;
    for (int i = 0; i < 20; i++) begin
      t = t + $urandom_range(1, 3000);
      if (i % 5 == 0) lvl = ~lvl;
      send_sample(t, lvl);
      if (i == 9) settle();
    end
    settle();
    stall_pct = 0;
  endtask

  task automatic test_random_runs(input int send_pct, input int stall_p, input int n);
    logic [TimeW-1:0] t;
    logic [DebW-1:0]  deb;
    logic [TimeW-1:0] interval;
    logic             want;
    int unsigned      pick;
    settle();
    pick = $urandom_range(99);
    if (pick < 70) deb = DebW'($urandom_range(300));
    else if (pick < 85) deb = DebW'($urandom);
    else deb = '0;
    pick = $urandom_range(99);
    if (pick < 60) interval = $urandom_range(100, 20000);
    else if (pick < 75) interval = 32'd1;
    else if (pick < 85) interval = '1;
    else interval = $urandom;
    configure(deb, 1'($urandom), interval);
    send_idle_pct = send_pct;
    stall_pct = stall_p;
    t = $urandom;
    want = 1'($urandom);
    for (int i = 0; i < n; i++) begin
      t = advance_ms(t);
      if ($urandom_range(99) < 4) want = ~want;
      // occasional contact bounce against the intended level
      send_sample(t, ($urandom_range(99) < 10) ? ~want : want);
    end
    settle();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_debounce_edges();
    test_register_extremes();
    test_backpressure();
    test_random_runs(0, 0, 360);
    test_random_runs(54, 0, 360);
    test_random_runs(0, 54, 360);
    test_random_runs(17, 17, 360);
    settle();
    repeat (2 * Latency) @(posedge clk_i);
    $display("covered %0d samples over %0d register settings", n_samples, n_settings);
    $display("saw %0d pump starts, %0d stops and %0d save pulses; %0d mismatches",
             n_starts, n_stops, n_saves, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
